@@ src/xbkd_pkg.sv @@
// Package for the byte-key XTEA decrypt core: item types, key register codes,
// and per-cell round constants. No dependencies.
package xbkd_pkg;

  localparam int unsigned ROUND_COUNT = 32;
  localparam int unsigned CELL_COUNT  = 2 * ROUND_COUNT;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned KEY_W       = 8;
  localparam int unsigned KEY_COUNT   = 4;
  localparam int unsigned KEY_SEL_W   = 2;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = KEY_W;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [KEY_W-1:0]       key_byte_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_A = 3'd0,
    REG_KEY_B = 3'd1,
    REG_KEY_C = 3'd2,
    REG_KEY_D = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    word_t cipher_low;
    word_t cipher_high;
  } in_item_t;

  typedef struct packed {
    word_t plain_low;
    word_t plain_high;
  } out_item_t;

  // Word pair carried along the chain: upd is the word this cell changes,
  // src feeds the mix function. Each cell swaps the two on the way out.
  typedef struct packed {
    word_t upd;
    word_t src;
  } cell_data_t;

  // Sum seen by a half-round cell. The first half of round r uses
  // DELTA*(ROUND_COUNT-r), the second half the value after one DELTA step.
  function automatic word_t cell_sum(input int unsigned idx);
    int unsigned steps;
    begin
      steps = ROUND_COUNT - (idx >> 1) - (idx & 1);
      cell_sum = word_t'(DELTA * word_t'(steps));
    end
  endfunction

  // Key element picked by a cell: sum bits 12:11 on the first half,
  // bits 1:0 on the second half.
  function automatic logic [KEY_SEL_W-1:0] cell_key_sel(input int unsigned idx);
    word_t s;
    begin
      s = cell_sum(idx);
      if ((idx & 1) == 0) begin
        cell_key_sel = s[12:11];
      end else begin
        cell_key_sel = s[1:0];
      end
    end
  endfunction

  function automatic word_t mix_word(input word_t w);
    mix_word = ((w << 4) ^ (w >> 5)) + w;
  endfunction

endpackage

@@ src/xbkd_cell.sv @@
// One half-round cell of the XTEA decrypt chain: subtract the keyed mix of
// one word from the other, swap, and register. Depends on xbkd_pkg.
module xbkd_cell import xbkd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       prev_valid,
  input  cell_data_t prev_data,
  input  word_t      sum,
  input  key_byte_t  key,
  output logic       valid,
  output cell_data_t data
);

  word_t      keyed_sum;
  cell_data_t data_next;

  always_comb begin
    keyed_sum      = sum + word_t'(key);
    data_next.upd  = prev_data.src;
    data_next.src  = prev_data.upd - (mix_word(prev_data.src) ^ keyed_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

@@ src/xtea_byte_key_decrypt_core.sv @@
// Byte-key XTEA decrypt core: 64 half-round cells in a registered chain.
// Throughput: one block per cycle; the whole chain advances together and
// holds only while the last cell has a result that is not taken.
// Reset (rst, synchronous): clears all cell valid bits and the four key bytes.
// Depends on xbkd_pkg and xbkd_cell.
module xtea_byte_key_decrypt_core import xbkd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_data
);

  key_byte_t  key_reg [KEY_COUNT];
  logic       chain_valid [CELL_COUNT+1];
  cell_data_t chain_data  [CELL_COUNT+1];
  logic       adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        key_reg[k] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_A: key_reg[0] <= cfg_data;
        REG_KEY_B: key_reg[1] <= cfg_data;
        REG_KEY_C: key_reg[2] <= cfg_data;
        REG_KEY_D: key_reg[3] <= cfg_data;
        default: ;  // drop writes beyond the key bytes
      endcase
    end
  end

  // Advance the chain unless the last cell holds an untaken result.
  assign adv      = !chain_valid[CELL_COUNT] || out_ready;
  assign in_ready = adv;

  assign chain_valid[0]    = in_valid;
  assign chain_data[0].upd = in_item.cipher_high;
  assign chain_data[0].src = in_item.cipher_low;

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    xbkd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (adv),
      .prev_valid (chain_valid[i]),
      .prev_data  (chain_data[i]),
      .sum        (cell_sum(i)),
      .key        (key_reg[cell_key_sel(i)]),
      .valid      (chain_valid[i+1]),
      .data       (chain_data[i+1])
    );
  end

  assign out_valid           = chain_valid[CELL_COUNT];
  assign out_item.plain_low  = chain_data[CELL_COUNT].src;
  assign out_item.plain_high = chain_data[CELL_COUNT].upd;

endmodule

@@ src/xbkd_checker.sv @@
// Port-level checker for the byte-key XTEA decrypt core, bound to the top.
// Depends on xbkd_pkg and xtea_byte_key_decrypt_core.
module xbkd_checker import xbkd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input out_item_t  out_item
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result dropped or changed");

  a_ready_on_take: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output side takes");

  a_ready_when_empty_out: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

endmodule

bind xtea_byte_key_decrypt_core xbkd_checker u_xbkd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
